// ===== hdl/pmh_pkg.sv =====
// ----------------------------------------------------------------------------
// pmh_pkg: shared types and constants for path_mean_heading
// Fixed-point constants, the arctangent table, CSR indices and cordic channel types.
// ----------------------------------------------------------------------------
package pmh_pkg;

   localparam int unsigned MEAN_POINTS_DEF = 5;
   localparam int unsigned CORDIC_STEPS    = 17;
   localparam int unsigned STEP_W          = 5;

   localparam logic [17:0] PI_Q16      = 18'd205887;
   localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
   localparam logic [15:0] PI_Q13      = 16'd25736;

   localparam logic [15:0] FRAME_WIDTH_RST  = 16'd640;
   localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // atan(2^-i) in Q16
   function automatic logic [16:0] atan_q16(input logic [STEP_W-1:0] i);
      logic [16:0] r;
      case (i)
         5'd0:  r = 17'd51472;
         5'd1:  r = 17'd30386;
         5'd2:  r = 17'd16055;
         5'd3:  r = 17'd8150;
         5'd4:  r = 17'd4091;
         5'd5:  r = 17'd2047;
         5'd6:  r = 17'd1024;
         5'd7:  r = 17'd512;
         5'd8:  r = 17'd256;
         5'd9:  r = 17'd128;
         5'd10: r = 17'd64;
         5'd11: r = 17'd32;
         5'd12: r = 17'd16;
         5'd13: r = 17'd8;
         5'd14: r = 17'd4;
         5'd15: r = 17'd2;
         5'd16: r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // cordic request and result between sequencer and unit
   typedef struct packed {
      logic        start;
      logic [16:0] ax;
      logic [16:0] ay;
   } cordic_req_type;

   typedef struct packed {
      logic        done;
      logic [17:0] angle;
   } cordic_rsp_type;

endpackage

// ===== hdl/pmh_if.sv =====
// ----------------------------------------------------------------------------
// pmh_if: valid/ready channel interfaces
// One interface for the point words and one for the heading words.
// ----------------------------------------------------------------------------
interface pmh_point_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_z;
   logic               last_point;

   modport source (output valid, point_x, point_z, last_point, input ready);
   modport sink   (input valid, point_x, point_z, last_point, output ready);
endinterface

interface pmh_heading_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] heading;
   logic               heading_valid;
   logic               path_valid;
   logic               last_result;

   modport source (output valid, heading, heading_valid, path_valid, last_result,
                   input ready);
   modport sink   (input valid, heading, heading_valid, path_valid, last_result,
                   output ready);
endinterface

// ===== hdl/pmh_cordic.sv =====
// ----------------------------------------------------------------------------
// pmh_cordic: iterative vectoring cordic
// First-quadrant angle of (ax, ay) in Q16, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module pmh_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  pmh_pkg::cordic_req_type req,
   output pmh_pkg::cordic_rsp_type rsp
);

   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [19:0] a_ff, a_in;
   logic [pmh_pkg::STEP_W-1:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [35:0] xs, ys;
   logic [35:0] xm, ym;
   logic signed [19:0] at;
   logic [17:0] clamp;

   // shift magnitudes so negative values truncate toward zero
   always_comb begin
      xm = x_ff[35] ? 36'(-x_ff) : 36'(x_ff);
      ym = y_ff[35] ? 36'(-y_ff) : 36'(y_ff);
      xs = x_ff[35] ? -$signed(xm >> i_ff) : $signed(xm >> i_ff);
      ys = y_ff[35] ? -$signed(ym >> i_ff) : $signed(ym >> i_ff);
      at = $signed({3'b000, pmh_pkg::atan_q16(i_ff)});
   end

   // one step per cycle
   always_comb begin
      x_in = x_ff; y_in = y_ff; a_in = a_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (req.start) begin
         x_in = $signed({5'd0, req.ax, 14'd0});
         y_in = $signed({5'd0, req.ay, 14'd0});
         a_in = '0; i_in = '0;
         if (req.ay == '0) begin
            done_in = 1'b1;
         end else if (req.ax == '0) begin
            a_in = $signed({2'b00, pmh_pkg::HALF_PI_Q16});
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (y_ff == '0 || i_ff == pmh_pkg::STEP_W'(pmh_pkg::CORDIC_STEPS)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            if (!y_ff[35]) begin
               x_in = x_ff + ys; y_in = y_ff - xs; a_in = a_ff + at;
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; a_in = a_ff - at;
            end
            i_in = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; a_ff <= a_in; i_ff <= i_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   // clamp to [0, pi/2]
   always_comb begin
      if (a_ff[19]) clamp = '0;
      else if (a_ff > $signed({2'b00, pmh_pkg::HALF_PI_Q16})) clamp = pmh_pkg::HALF_PI_Q16;
      else clamp = a_ff[17:0];
      rsp.done  = done_ff;
      rsp.angle = clamp;
   end

endmodule

// ===== hdl/path_mean_heading.sv =====
// Work per result word: a cordic heading for up to 9 pairs (MEAN_POINTS of 5),
//   then a restoring division of the heading sum by the pair count.
// Flow: one point word at a time, taken only while idle; a path's last point
//   flushes up to MEAN_POINTS+1 results, each sent once the last one is taken.
// Reset: synchronous active high; clears window, point counts, CSRs to defaults.
// ----------------------------------------------------------------------------
// path_mean_heading: mean heading over a sliding window of path points
// Sequencer around a shared cordic unit and a serial divider.
// ----------------------------------------------------------------------------
module path_mean_heading #(
   parameter int unsigned MEAN_POINTS = pmh_pkg::MEAN_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pmh_point_if.sink   req,
   pmh_heading_if.source rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned WIN = 2 * MEAN_POINTS + 1;
   localparam int unsigned IW  = $clog2(WIN);
   localparam int unsigned CW  = $clog2(MEAN_POINTS + 2);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EMIT  = 9'b000000010,
      S_PAIR  = 9'b000000100,
      S_WAIT  = 9'b000001000,
      S_NEXT  = 9'b000010000,
      S_REV   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_OUT   = 9'b010000000,
      S_HOLD  = 9'b100000000
   } state_type;

   state_type st_ff, st_in;
   logic [15:0] fw_ff, fh_ff;
   logic signed [15:0] wx_ff [WIN], wz_ff [WIN];
   logic [CW-1:0] seen_ff, seen_in;
   logic [15:0] epos_ff, epos_in;
   logic ok_ff, ok_in, last_ff, last_in, rev_ff, rev_in, valid_ff, valid_in;
   logic [CW-1:0] j_ff, j_in, cnt_ff, cnt_in;
   logic signed [19:0] sum_ff, sum_in;
   logic signed [16:0] bx_ff, by_ff;
   logic [IW-1:0] idx, ia, ib;
   logic signed [15:0] x1, z1, x2, z2;
   logic pair_ok;
   logic pair_go;
   logic signed [16:0] bx, by;
   pmh_pkg::cordic_req_type creq;
   pmh_pkg::cordic_rsp_type crsp;
   logic [17:0] m;
   logic [15:0] hmag;
   logic signed [16:0] h;
   logic [19:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0] dk_ff, dk_in;
   logic [20:0] trial;
   logic signed [15:0] hd_ff, hd_in;
   logic hv_ff, hv_in, pv_ff, pv_in, lr_ff, lr_in, ov_ff, ov_in;
   logic shift_en;
   logic [19:0] mag;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= pmh_pkg::FRAME_WIDTH_RST; fh_ff <= pmh_pkg::FRAME_HEIGHT_RST;
      end else if (csr_write) begin
         if (csr_index == pmh_pkg::CSR_FRAME_WIDTH) fw_ff <= csr_data;
         else fh_ff <= csr_data;
      end
   end

   assign req.ready = (st_ff == S_IDLE);
   assign shift_en  = req.valid && req.ready;

   // point window, newest at top
   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN; i++) begin
         if (reset || (st_ff == S_EMIT && last_ff && seen_ff == '0)) begin
            wx_ff[i] <= '0; wz_ff[i] <= '0;
         end else if (shift_en) begin
            if (i == WIN - 1) begin
               wx_ff[i] <= req.point_x; wz_ff[i] <= req.point_z;
            end else begin
               wx_ff[i] <= wx_ff[i+1]; wz_ff[i] <= wz_ff[i+1];
            end
         end
      end
   end

   // pair selection and validity
   always_comb begin
      idx = IW'(WIN) - IW'(seen_ff);
      if (!rev_ff) begin
         ia = idx; ib = idx + IW'(j_ff);
      end else begin
         ia = idx - IW'(j_ff); ib = idx;
      end
      x1 = wx_ff[ia]; z1 = wz_ff[ia]; x2 = wx_ff[ib]; z2 = wz_ff[ib];
      pair_ok = !(x1 == x2 && z1 == z2) && !x1[15] && !z1[15] && !x2[15] && !z2[15]
         && (x1[14:0] < fw_ff) && (x2[14:0] < fw_ff)
         && (z1[14:0] < fh_ff) && (z2[14:0] < fh_ff);
      bx = 17'(z1) - 17'(z2);
      by = 17'(x2) - 17'(x1);
      // start only for a pair inside the window and inside the path
      pair_go = (st_ff == S_PAIR) && (j_ff <= CW'(MEAN_POINTS))
         && (rev_ff ? (16'(j_ff) <= epos_ff) : (j_ff <= seen_ff - 1'b1));
      creq.start = pair_go && pair_ok;
      creq.ax = bx[16] ? 17'(-bx) : 17'(bx);
      creq.ay = by[16] ? 17'(-by) : 17'(by);
   end

   pmh_cordic u_cordic (.clock(clock), .reset(reset), .req(creq), .rsp(crsp));

   // quadrant fix and rounding to Q13
   always_comb begin
      m = bx_ff[16] ? pmh_pkg::PI_Q16 - crsp.angle : crsp.angle;
      hmag = 16'((m + 18'd4) >> 3);
      h = by_ff[16] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
      if (h == -$signed({1'b0, pmh_pkg::PI_Q13})) h = $signed({1'b0, pmh_pkg::PI_Q13});
      mag = sum_ff[19] ? 20'(-sum_ff) : 20'(sum_ff);
      trial = {rem_ff, quo_ff[19]} - 21'(cnt_ff);
   end

   // sequencer
   always_comb begin
      st_in = st_ff; seen_in = seen_ff; epos_in = epos_ff; ok_in = ok_ff;
      last_in = last_ff; rev_in = rev_ff; valid_in = valid_ff; j_in = j_ff;
      cnt_in = cnt_ff; sum_in = sum_ff; rem_in = rem_ff; quo_in = quo_ff;
      dk_in = dk_ff; hd_in = hd_ff; hv_in = hv_ff; pv_in = pv_ff; lr_in = lr_ff;
      ov_in = ov_ff;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (shift_en) begin
               seen_in = seen_ff + 1'b1;
               last_in = req.last_point;
               if (req.last_point || seen_ff + 1'b1 >= CW'(MEAN_POINTS + 1))
                  st_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (seen_ff == '0) begin
               epos_in = '0; ok_in = 1'b1; last_in = 1'b0; st_in = S_IDLE;
            end else begin
               rev_in = 1'b0; j_in = CW'(1); cnt_in = '0; sum_in = '0;
               valid_in = 1'b1; st_in = S_PAIR;
            end
         end
         S_PAIR: begin
            if (!rev_ff && (j_ff > CW'(MEAN_POINTS) || j_ff > seen_ff - 1'b1)) begin
               st_in = S_NEXT;
            end else if (rev_ff && j_ff > CW'(MEAN_POINTS)) begin
               st_in = S_DIV;
            end else if (rev_ff && 16'(j_ff) > epos_ff) begin
               valid_in = 1'b0; cnt_in = '0; st_in = S_DIV;
            end else if (!pair_ok) begin
               st_in = rev_ff ? S_DIV : S_NEXT;
            end else begin
               st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (crsp.done) begin
               sum_in = sum_ff + 20'(h); cnt_in = cnt_ff + 1'b1;
               j_in = j_ff + 1'b1; st_in = S_PAIR;
            end
         end
         S_NEXT: begin
            if (cnt_ff == CW'(MEAN_POINTS)) begin
               st_in = S_DIV;
            end else begin
               rev_in = 1'b1; j_in = CW'(1); cnt_in = '0; sum_in = '0; st_in = S_PAIR;
            end
         end
         S_DIV: begin
            if (dk_ff == '0 && quo_ff == '0 && rem_ff == '0 && !rev_in) begin
               rem_in = '0;
            end
            if (cnt_ff == '0) begin
               valid_in = 1'b0; st_in = S_OUT;
            end else if (dk_ff == '0) begin
               rem_in = '0; quo_in = mag + 20'(cnt_ff >> 1); dk_in = 5'd20;
            end else begin
               if (!trial[20]) begin
                  rem_in = trial[19:0]; quo_in = {quo_ff[18:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[18:0], quo_ff[19]}; quo_in = {quo_ff[18:0], 1'b0};
               end
               dk_in = dk_ff - 1'b1;
               if (dk_ff == 5'd1) st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff) begin
               hv_in = valid_ff;
               hd_in = !valid_ff ? '0 : (sum_ff[19] ? 16'(-quo_ff) : 16'(quo_ff));
               lr_in = last_ff && seen_ff == CW'(1);
               pv_in = lr_in && ok_ff && valid_ff;
               if (!valid_ff) ok_in = 1'b0;
               ov_in = 1'b1;
               seen_in = seen_ff - 1'b1;
               if (epos_ff != 16'hFFFF) epos_in = epos_ff + 1'b1;
               st_in = S_HOLD;
            end
         end
         S_HOLD: begin
            st_in = last_ff ? S_EMIT : S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_PAIR) begin
         bx_ff <= bx; by_ff <= by;
      end
      j_ff <= j_in; cnt_ff <= cnt_in; sum_ff <= sum_in; rem_ff <= rem_in;
      quo_ff <= quo_in; hd_ff <= hd_in; hv_ff <= hv_in; pv_ff <= pv_in;
      lr_ff <= lr_in; rev_ff <= rev_in; valid_ff <= valid_in;
      if (reset) begin
         st_ff <= S_IDLE; seen_ff <= '0; epos_ff <= '0; ok_ff <= 1'b1;
         last_ff <= 1'b0; ov_ff <= 1'b0; dk_ff <= '0;
      end else begin
         st_ff <= st_in; seen_ff <= seen_in; epos_ff <= epos_in; ok_ff <= ok_in;
         last_ff <= last_in; ov_ff <= ov_in; dk_ff <= dk_in;
      end
   end

   // result word register
   assign rsp.valid         = ov_ff;
   assign rsp.heading       = hd_ff;
   assign rsp.heading_valid = hv_ff;
   assign rsp.path_valid    = pv_ff;
   assign rsp.last_result   = lr_ff;

endmodule
